// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the field splitter sequencer
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is high
`define QFS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, checked during reset as well
`define QFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/qfs_pkg.sv
// ----------------------------------------------------------------------------
// qfs_pkg
// shared widths and character constants of the quoted field splitter
// ----------------------------------------------------------------------------
package qfs_pkg;

   // character width of requests and responses
   localparam int CHAR_W = 8;

   // default field buffer depth
   localparam int MAX_FIELD_CHARS_DEF = 32;

   // double quote code
   localparam logic [CHAR_W-1:0] QUOTE_CODE = 8'h22;

   // separator after reset (comma)
   localparam logic [CHAR_W-1:0] SEP_RESET = 8'd44;

endpackage

// File: src/qfs_if.sv
// ----------------------------------------------------------------------------
// qfs_if
// request and response channels of the quoted field splitter
// ----------------------------------------------------------------------------

// request channel: at most one record character per request
interface qfs_req_if import qfs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              carries_char;
   logic              ends_record;

   modport source (output valid, output char_code, output carries_char,
                   output ends_record, input ready);
   modport sink   (input valid, input char_code, input carries_char,
                   input ends_record, output ready);
endinterface

// response channel: at most one field character per response
interface qfs_rsp_if import qfs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] field_char;
   logic              has_char;
   logic              field_end;
   logic              record_end;
   logic              field_truncated;
   logic              quotes_balanced;
   logic              run_last;

   modport source (output valid, output field_char, output has_char,
                   output field_end, output record_end, output field_truncated,
                   output quotes_balanced, output run_last, input ready);
   modport sink   (input valid, input field_char, input has_char,
                   input field_end, input record_end, input field_truncated,
                   input quotes_balanced, input run_last, output ready);
endinterface

// File: src/quoted_field_splitter_core.sv
// ----------------------------------------------------------------------------
// quoted_field_splitter_core
// splits a character stream into separator-delimited fields with quoting
// ----------------------------------------------------------------------------
// Requests are taken one at a time. A request carrying a character is accepted
// in S_IDLE and, if a character is already held, followed by the quote decision
// for the held character in S_DEC_NEXT. A request that closes a field replays
// that field from the field buffer, each character a buffer read (S_EMIT_RD)
// then a response load (S_EMIT_WR), one empty response (S_EMPTY) for an empty
// field, after a setup step (S_FINAL) for the final field of a record; response
// stalls hold the replay. Replay uses the single read port of the field buffer.
// The buffer needs no clearing pass after reset. The separator register may
// be written only while no request is in progress.
module quoted_field_splitter_core import qfs_pkg::*; #(
   parameter int MAX_FIELD_CHARS = MAX_FIELD_CHARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   qfs_req_if.sink           req_chan,
   qfs_rsp_if.source         rsp_chan,
   input  logic              csr_wr_en,
   input  logic [CHAR_W-1:0] csr_wr_data
);

   localparam int ADDR_W = (MAX_FIELD_CHARS > 1) ? $clog2(MAX_FIELD_CHARS) : 1;

   logic [CHAR_W-1:0] sep_ff, sep_in;
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [CHAR_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [CHAR_W-1:0] mem_rd_data;

   // separator register
   assign sep_in = csr_wr_en ? csr_wr_data : sep_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= SEP_RESET;
      end else begin
         sep_ff <= sep_in;
      end
   end

   // sequencer
   qfs_ctrl #(
      .MAX_FIELD_CHARS (MAX_FIELD_CHARS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .sep_char    (sep_ff),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // field buffer
   qfs_field_mem #(
      .DEPTH (MAX_FIELD_CHARS)
   ) u_field_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// File: src/qfs_field_mem.sv
// ----------------------------------------------------------------------------
// qfs_field_mem
// field character buffer, one write and one registered read port
// ----------------------------------------------------------------------------
module qfs_field_mem import qfs_pkg::*; #(
   parameter int DEPTH = MAX_FIELD_CHARS_DEF
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [CHAR_W-1:0]                    wr_data,
   input  logic                                 rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [CHAR_W-1:0]                    rd_data
);

   logic [CHAR_W-1:0] store_ff [DEPTH];
   logic [CHAR_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered, holds between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/qfs_ctrl.sv
// ----------------------------------------------------------------------------
// qfs_ctrl
// quote decision sequencer, field length and trim tracking, field replay
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qfs_ctrl import qfs_pkg::*; #(
   parameter int MAX_FIELD_CHARS = MAX_FIELD_CHARS_DEF,
   localparam int LEN_W  = $clog2(MAX_FIELD_CHARS + 1),
   localparam int ADDR_W = (MAX_FIELD_CHARS > 1) ? $clog2(MAX_FIELD_CHARS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CHAR_W-1:0] sep_char,
   qfs_req_if.sink           req,
   qfs_rsp_if.source         rsp,
   output logic              mem_wr_en,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output logic [CHAR_W-1:0] mem_wr_data,
   output logic              mem_rd_en,
   output logic [ADDR_W-1:0] mem_rd_addr,
   input  logic [CHAR_W-1:0] mem_rd_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEC_NEXT,
      S_DEC_LAST,
      S_FINAL,
      S_EMIT_RD,
      S_EMIT_WR,
      S_EMPTY
   } state_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_PUT,
      ACT_EMIT
   } action_type;

   // trimmed whitespace codes
   function automatic logic is_space(input logic [CHAR_W-1:0] c);
      return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32) || (c == 8'h85) ||
             (c == 8'hA0);
   endfunction

   state_type         state_ff, state_in;
   logic [CHAR_W-1:0] in_char_ff, in_char_in;
   logic              in_ends_ff, in_ends_in;
   logic [CHAR_W-1:0] pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [CHAR_W-1:0] prev_ff, prev_in;
   logic              at_start_ff, at_start_in;
   logic              inside_ff, inside_in;
   logic              skip_ff, skip_in;
   logic              ovf_ff, ovf_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              any_ns_ff, any_ns_in;
   logic [LEN_W-1:0]  lead_ff, lead_in;
   logic [LEN_W-1:0]  tstop_ff, tstop_in;
   logic [LEN_W-1:0]  em_addr_ff, em_addr_in;
   logic [LEN_W-1:0]  em_stop_ff, em_stop_in;
   logic              em_final_ff, em_final_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_has_ff, rsp_has_in;
   logic              rsp_fend_ff, rsp_fend_in;
   logic              rsp_rend_ff, rsp_rend_in;
   logic              rsp_trunc_ff, rsp_trunc_in;
   logic              rsp_bal_ff, rsp_bal_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              slot_free;
   logic              rsp_load;
   logic              field_done;
   logic              dec_apply;
   logic              dec_has_next;
   logic              may_open;
   action_type        dec_act;
   logic              dec_skip;
   logic              dec_inside;
   logic [LEN_W-1:0]  em_next;
   logic              em_fend;

   assign slot_free    = !rsp_valid_ff || rsp.ready;
   assign dec_has_next = (state_ff == S_DEC_NEXT);
   assign may_open     = at_start_ff || (prev_ff == sep_char);
   assign em_next      = em_addr_ff + LEN_W'(1);
   assign em_fend      = (em_next == em_stop_ff);

   // quote decision for the pending character, lookahead is the new character
   always_comb begin
      dec_act    = ACT_NONE;
      dec_skip   = 1'b0;
      dec_inside = inside_ff;
      priority if (skip_ff) begin
         dec_act = ACT_NONE;
      end else if (pend_ff == QUOTE_CODE) begin
         priority if (may_open && !inside_ff) begin
            dec_inside = 1'b1;
         end else if ((!dec_has_next || (in_char_ff == sep_char)) && inside_ff) begin
            dec_inside = 1'b0;
         end else if (dec_has_next && (in_char_ff == QUOTE_CODE)) begin
            dec_act  = ACT_PUT;
            dec_skip = 1'b1;
         end else begin
            dec_act = ACT_PUT;
         end
      end else if (!inside_ff && (pend_ff == sep_char)) begin
         dec_act = ACT_EMIT;
      end else begin
         dec_act = ACT_PUT;
      end
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      in_char_in    = in_char_ff;
      in_ends_in    = in_ends_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      prev_in       = prev_ff;
      at_start_in   = at_start_ff;
      inside_in     = inside_ff;
      skip_in       = skip_ff;
      ovf_in        = ovf_ff;
      len_in        = len_ff;
      any_ns_in     = any_ns_ff;
      lead_in       = lead_ff;
      tstop_in      = tstop_ff;
      em_addr_in    = em_addr_ff;
      em_stop_in    = em_stop_ff;
      em_final_in   = em_final_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_char_in   = rsp_char_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_fend_in   = rsp_fend_ff;
      rsp_rend_in   = rsp_rend_ff;
      rsp_trunc_in  = rsp_trunc_ff;
      rsp_bal_in    = rsp_bal_ff;
      rsp_last_in   = rsp_last_ff;

      mem_wr_en     = 1'b0;
      mem_wr_addr   = len_ff[ADDR_W-1:0];
      mem_wr_data   = pend_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = em_addr_ff[ADDR_W-1:0];
      rsp_load      = 1'b0;
      field_done    = 1'b0;
      dec_apply     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               in_char_in = req.char_code;
               in_ends_in = req.ends_record;
               if (req.carries_char) begin
                  if (pend_valid_ff) begin
                     state_in = S_DEC_NEXT;
                  end else begin
                     pend_in       = req.char_code;
                     pend_valid_in = 1'b1;
                     state_in      = req.ends_record ? S_DEC_LAST : S_IDLE;
                  end
               end else if (req.ends_record) begin
                  state_in = pend_valid_ff ? S_DEC_LAST : S_FINAL;
               end
            end
         end
         S_DEC_NEXT: begin
            dec_apply = 1'b1;
            pend_in   = in_char_ff;
            state_in  = in_ends_ff ? S_DEC_LAST : S_IDLE;
         end
         S_DEC_LAST: begin
            dec_apply     = 1'b1;
            pend_valid_in = 1'b0;
            state_in      = S_FINAL;
         end
         S_FINAL: begin
            // final field replays only the span between trimmed whitespace
            em_final_in = 1'b1;
            if (any_ns_ff) begin
               em_addr_in = lead_ff;
               em_stop_in = tstop_ff;
               state_in   = S_EMIT_RD;
            end else begin
               state_in   = S_EMPTY;
            end
         end
         S_EMIT_RD: begin
            mem_rd_en = 1'b1;
            state_in  = S_EMIT_WR;
         end
         S_EMIT_WR: begin
            if (slot_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_char_in  = mem_rd_data;
               rsp_has_in   = 1'b1;
               rsp_fend_in  = em_fend;
               rsp_rend_in  = em_final_ff && em_fend;
               rsp_trunc_in = ovf_ff;
               rsp_bal_in   = em_final_ff && em_fend && !inside_ff;
               rsp_last_in  = em_fend && (em_final_ff || !in_ends_ff);
               if (em_fend) begin
                  field_done = 1'b1;
               end else begin
                  em_addr_in = em_next;
                  state_in   = S_EMIT_RD;
               end
            end
         end
         S_EMPTY: begin
            if (slot_free) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_char_in  = '0;
               rsp_has_in   = 1'b0;
               rsp_fend_in  = 1'b1;
               rsp_rend_in  = em_final_ff;
               rsp_trunc_in = ovf_ff;
               rsp_bal_in   = em_final_ff && !inside_ff;
               rsp_last_in  = em_final_ff || !in_ends_ff;
               field_done   = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // apply the quote decision
      if (dec_apply) begin
         skip_in     = dec_skip;
         inside_in   = dec_inside;
         prev_in     = pend_ff;
         at_start_in = 1'b0;
         unique case (dec_act)
            ACT_PUT: begin
               if (len_ff < LEN_W'(MAX_FIELD_CHARS)) begin
                  mem_wr_en = 1'b1;
                  len_in    = len_ff + LEN_W'(1);
                  if (!is_space(pend_ff)) begin
                     if (!any_ns_ff) begin
                        lead_in = len_ff;
                     end
                     any_ns_in = 1'b1;
                     tstop_in  = len_ff + LEN_W'(1);
                  end
               end else begin
                  ovf_in = 1'b1;
               end
            end
            ACT_EMIT: begin
               em_final_in = 1'b0;
               if (len_ff == '0) begin
                  state_in   = S_EMPTY;
               end else begin
                  em_addr_in = '0;
                  em_stop_in = len_ff;
                  state_in   = S_EMIT_RD;
               end
            end
            ACT_NONE: begin
               skip_in = dec_skip;
            end
            default: begin
               skip_in = dec_skip;
            end
         endcase
      end

      // field replay finished: reset the field tracking, pick up the rest of the request
      if (field_done) begin
         len_in    = '0;
         ovf_in    = 1'b0;
         any_ns_in = 1'b0;
         lead_in   = '0;
         tstop_in  = '0;
         if (em_final_ff) begin
            pend_in       = '0;
            pend_valid_in = 1'b0;
            prev_in       = '0;
            at_start_in   = 1'b1;
            inside_in     = 1'b0;
            skip_in       = 1'b0;
            state_in      = S_IDLE;
         end else if (!in_ends_ff) begin
            state_in = S_IDLE;
         end else begin
            state_in = pend_valid_ff ? S_DEC_LAST : S_FINAL;
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_ff       <= '0;
         pend_valid_ff <= 1'b0;
         prev_ff       <= '0;
         at_start_ff   <= 1'b1;
         inside_ff     <= 1'b0;
         skip_ff       <= 1'b0;
         ovf_ff        <= 1'b0;
         len_ff        <= '0;
         any_ns_ff     <= 1'b0;
         lead_ff       <= '0;
         tstop_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         pend_valid_ff <= pend_valid_in;
         prev_ff       <= prev_in;
         at_start_ff   <= at_start_in;
         inside_ff     <= inside_in;
         skip_ff       <= skip_in;
         ovf_ff        <= ovf_in;
         len_ff        <= len_in;
         any_ns_ff     <= any_ns_in;
         lead_ff       <= lead_in;
         tstop_ff      <= tstop_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      in_char_ff   <= in_char_in;
      in_ends_ff   <= in_ends_in;
      em_addr_ff   <= em_addr_in;
      em_stop_ff   <= em_stop_in;
      em_final_ff  <= em_final_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_has_ff   <= rsp_has_in;
      rsp_fend_ff  <= rsp_fend_in;
      rsp_rend_ff  <= rsp_rend_in;
      rsp_trunc_ff <= rsp_trunc_in;
      rsp_bal_ff   <= rsp_bal_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // channel ports
   assign req.ready           = (state_ff == S_IDLE);
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.field_char      = rsp_char_ff;
   assign rsp.has_char        = rsp_has_ff;
   assign rsp.field_end       = rsp_fend_ff;
   assign rsp.record_end      = rsp_rend_ff;
   assign rsp.field_truncated = rsp_trunc_ff;
   assign rsp.quotes_balanced = rsp_bal_ff;
   assign rsp.run_last        = rsp_last_ff;

   // checks
   `QFS_ASSERT(a_load_slot_free, clock, reset, rsp_load |-> (!rsp_valid_ff || rsp.ready), "response overwritten while stalled")
   `QFS_ASSERT(a_rd_in_range, clock, reset, (state_ff == S_EMIT_RD) |-> (em_addr_ff < em_stop_ff), "replay address past field end")
   `QFS_ASSERT(a_lookahead_pending, clock, reset, (state_ff == S_DEC_NEXT) |-> pend_valid_ff, "lookahead decision without pending character")
   `QFS_ASSERT(a_record_cleared, clock, reset, (field_done && em_final_ff) |=> (at_start_ff && !pend_valid_ff && (len_ff == '0)), "record state not cleared after final field")
   `QFS_ASSERT(a_rend_is_last, clock, reset, (rsp_valid_ff && rsp_rend_ff) |-> (rsp_last_ff && rsp_fend_ff), "record end not on last response")

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the quoted field splitter against a cycle-free model of its splitting
// ----------------------------------------------------------------------------
// Directed records exercise quote opening and closing, doubled quotes,
// literal separators, trimming, empty and unbalanced records. Random records
// follow under several separators (0, 255, quote, comma, semicolon), with long
// fields to overflow the buffer, a separator change inside an open record,
// idle requests, noise, random gaps on both channels and one long response
// hold-off. Every response is checked in order against the predicted beats.
// ----------------------------------------------------------------------------
module tb;
   import qfs_pkg::*;

   localparam int FIELD_CAP     = MAX_FIELD_CHARS_DEF;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 10;
   localparam int TIMEOUT_TIME  = 20_000_000;
   localparam int MAX_REPORTS   = 10;

   // one request item
   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              carries;
      logic              ends;
   } rec_item_type;

   // one response beat
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              has;
      logic              fend;
      logic              rend;
      logic              trunc;
      logic              bal;
      logic              last;
   } field_beat_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [CHAR_W-1:0] csr_wr_data;

   qfs_req_if req_if ();
   qfs_rsp_if rsp_if ();

   quoted_field_splitter_core #(.MAX_FIELD_CHARS(FIELD_CAP)) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // splitter model state
   logic [CHAR_W-1:0] sep_now = SEP_RESET;
   logic [CHAR_W-1:0] field_copy [FIELD_CAP];
   int unsigned       field_len = 0;
   logic [CHAR_W-1:0] held_char = '0;
   bit                held_valid = 1'b0;
   logic [CHAR_W-1:0] last_char = '0;
   bit                record_start = 1'b1;
   bit                quoted_open = 1'b0;
   bit                drop_next = 1'b0;
   bit                overflowed = 1'b0;

   field_beat_type item_beats[$];
   field_beat_type expected_beats[$];
   rec_item_type   pending_items[$];

   // run control and counters
   bit          idle_on = 1'b1;
   logic        hold_kick;
   int          hold_left;
   int          gap_left = 0;
   int          stall_left = 0;
   int          mismatches = 0;
   int          req_count = 0;
   int          records_done = 0;
   int          beats_checked = 0;
   int          trunc_beats = 0;
   int          unbalanced_records = 0;
   int          random_items = 0;

   function automatic bit is_blank(input logic [CHAR_W-1:0] c);
      return (c >= 8'd9 && c <= 8'd13) || c == 8'd32 || c == 8'h85 || c == 8'hA0;
   endfunction

   function automatic void keep_char(input logic [CHAR_W-1:0] c);
      if (field_len < FIELD_CAP) begin
         field_copy[field_len] = c;
         field_len++;
      end else begin
         overflowed = 1'b1;
      end
   endfunction

   function automatic void add_beat(input logic [CHAR_W-1:0] c, input bit has,
                                    input bit fend, input bit rend, input bit bal);
      field_beat_type b;
      b.ch    = has ? c : '0;
      b.has   = has;
      b.fend  = fend;
      b.rend  = rend;
      b.trunc = overflowed;
      b.bal   = rend && bal;
      b.last  = 1'b0;
      item_beats.push_back(b);
   endfunction

   // replay kept characters first..stop-1, or one empty beat
   function automatic void flush_field(input int unsigned first, input int unsigned stop,
                                       input bit last_fld, input bit bal);
      if (stop <= first) begin
         add_beat('0, 1'b0, 1'b1, last_fld, bal);
      end else begin
         for (int unsigned k = first; k < stop; k++)
            add_beat(field_copy[k], 1'b1, k + 1 == stop, last_fld && k + 1 == stop, bal);
      end
      field_len  = 0;
      overflowed = 1'b0;
   endfunction

   // quote and separator decision for the held character
   function automatic void quote_decide(input logic [CHAR_W-1:0] c, input bit more,
                                        input logic [CHAR_W-1:0] nxt);
      bit can_open;
      if (drop_next) begin
         drop_next    = 1'b0;
         last_char    = c;
         record_start = 1'b0;
         return;
      end
      can_open     = record_start || last_char == sep_now;
      record_start = 1'b0;
      last_char    = c;
      if (c == QUOTE_CODE) begin
         if (can_open && !quoted_open) begin
            quoted_open = 1'b1;
         end else if ((!more || nxt == sep_now) && quoted_open) begin
            quoted_open = 1'b0;
         end else if (more && nxt == QUOTE_CODE) begin
            keep_char(QUOTE_CODE);
            drop_next = 1'b1;
         end else begin
            keep_char(QUOTE_CODE);
         end
      end else if (!quoted_open && c == sep_now) begin
         flush_field(0, field_len, 1'b0, 1'b0);
      end else begin
         keep_char(c);
      end
   endfunction

   // predicts the response beats of one accepted request
   function automatic void split_request(input logic [CHAR_W-1:0] c, input logic carries,
                                         input logic ends);
      int unsigned    first;
      int unsigned    stop;
      field_beat_type b;
      item_beats.delete();
      if (carries) begin
         if (held_valid)
            quote_decide(held_char, 1'b1, c);
         held_char  = c;
         held_valid = 1'b1;
      end
      if (ends) begin
         if (held_valid) begin
            held_valid = 1'b0;
            quote_decide(held_char, 1'b0, '0);
         end
         first = 0;
         stop  = field_len;
         while (first < stop && is_blank(field_copy[first]))
            first++;
         while (stop > first && is_blank(field_copy[stop-1]))
            stop--;
         flush_field(first, stop, 1'b1, !quoted_open);
         field_len    = 0;
         held_char    = '0;
         held_valid   = 1'b0;
         last_char    = '0;
         record_start = 1'b1;
         quoted_open  = 1'b0;
         drop_next    = 1'b0;
         overflowed   = 1'b0;
      end
      if (item_beats.size() > 0) begin
         b = item_beats.pop_back();
         b.last = 1'b1;
         item_beats.push_back(b);
      end
      foreach (item_beats[i])
         expected_beats.push_back(item_beats[i]);
   endfunction

   // request driver
   always @(posedge clock) begin
      rec_item_type nxt;
      logic         offer;
      if (reset) begin
         req_if.valid        <= 1'b0;
         req_if.char_code    <= '0;
         req_if.carries_char <= 1'b0;
         req_if.ends_record  <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            split_request(req_if.char_code, req_if.carries_char, req_if.ends_record);
            req_count++;
            if (req_if.ends_record)
               records_done++;
         end
         if (!req_if.valid || req_if.ready) begin
            offer = 1'b0;
            nxt   = '0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() > 0) begin
               if (idle_on && $urandom_range(0, 9) == 0) begin
                  gap_left = $urandom_range(1, 18) - 1;
               end else begin
                  nxt   = pending_items.pop_front();
                  offer = 1'b1;
               end
            end
            req_if.valid <= offer;
            if (offer) begin
               req_if.char_code    <= nxt.code;
               req_if.carries_char <= nxt.carries;
               req_if.ends_record  <= nxt.ends;
            end
         end
      end
   end

   // long response hold-off
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_kick)
         hold_left <= HOLD_CYCLES;
      else if (hold_left > 0)
         hold_left <= hold_left - 1;
   end

   // response monitor and checker
   always @(posedge clock) begin
      field_beat_type got;
      field_beat_type want;
      logic           rdy;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.ch    = rsp_if.field_char;
            got.has   = rsp_if.has_char;
            got.fend  = rsp_if.field_end;
            got.rend  = rsp_if.record_end;
            got.trunc = rsp_if.field_truncated;
            got.bal   = rsp_if.quotes_balanced;
            got.last  = rsp_if.run_last;
            if (got.trunc === 1'b1)
               trunc_beats++;
            if (got.rend === 1'b1 && got.bal === 1'b0)
               unbalanced_records++;
            if (expected_beats.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected: ch %02h has %b fe %b re %b tr %b bal %b last %b",
                           got.ch, got.has, got.fend, got.rend, got.trunc, got.bal, got.last);
            end else begin
               want = expected_beats.pop_front();
               beats_checked++;
               if (got.ch !== want.ch || got.has !== want.has || got.fend !== want.fend ||
                   got.rend !== want.rend || got.trunc !== want.trunc ||
                   got.bal !== want.bal || got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("mismatch on response %0d:", beats_checked);
                     $display("  expected ch %02h has %b fe %b re %b tr %b bal %b last %b",
                              want.ch, want.has, want.fend, want.rend, want.trunc, want.bal,
                              want.last);
                     $display("  actual   ch %02h has %b fe %b re %b tr %b bal %b last %b",
                              got.ch, got.has, got.fend, got.rend, got.trunc, got.bal,
                              got.last);
                  end
               end
            end
         end
         // ready with random stall bursts
         if (hold_left > 0) begin
            rdy = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
         end
         rsp_if.ready <= rdy;
      end
   end

   // stimulus helpers
   task automatic push_item(input logic [CHAR_W-1:0] c, input logic carries,
                            input logic ends);
      rec_item_type it;
      it.code    = c;
      it.carries = carries;
      it.ends    = ends;
      pending_items.push_back(it);
   endtask

   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++)
         push_item(s[i], 1'b1, 1'b0);
   endtask

   function automatic logic [CHAR_W-1:0] pick_char();
      logic [CHAR_W-1:0] blanks [8] = '{8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32,
                                        8'h85, 8'hA0};
      case ($urandom_range(0, 9))
         0: return sep_now;
         1: return QUOTE_CODE;
         2: return blanks[$urandom_range(0, 7)];
         3: return CHAR_W'($urandom_range(0, 255));
         default: return 8'h61 + CHAR_W'($urandom_range(0, 25));
      endcase
   endfunction

   // random record, mostly well formed; finish=0 leaves it open
   task automatic add_random_record(input bit finish);
      int      nfields;
      int      len;
      int      pushed;
      bit      quoted;
      if ($urandom_range(0, 7) == 0) begin
         // noise burst
         repeat ($urandom_range(1, 5)) begin
            push_item(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      $urandom_range(0, 3) == 0);
            random_items++;
         end
         return;
      end
      pushed  = 0;
      nfields = $urandom_range(1, 4);
      for (int f = 0; f < nfields; f++) begin
         if (f > 0) begin
            push_item(sep_now, 1'b1, 1'b0);
            pushed++;
         end
         quoted = $urandom_range(0, 2) == 0;
         len = ($urandom_range(0, 24) == 0) ? $urandom_range(FIELD_CAP + 1, FIELD_CAP + 8)
                                             : $urandom_range(0, 6);
         if (quoted) begin
            push_item(QUOTE_CODE, 1'b1, 1'b0);
            pushed++;
         end
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 14) == 0) begin
               push_item(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0);
               pushed++;
            end
            push_item(pick_char(), 1'b1, 1'b0);
            pushed++;
         end
         if (quoted) begin
            push_item(QUOTE_CODE, 1'b1, 1'b0);
            pushed++;
         end
      end
      if (finish) begin
         if (pushed > 0 && $urandom_range(0, 1) == 1) begin
            pending_items[pending_items.size()-1].ends = 1'b1;
         end else begin
            push_item(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b1);
            pushed++;
         end
      end
      random_items += pushed;
   endtask

   // waits until nothing is in flight
   task automatic drain();
      @(negedge clock);
      while (pending_items.size() > 0 || req_if.valid || expected_beats.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_separator(input logic [CHAR_W-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sep_now = v;
   endtask

   task automatic random_phase(input logic [CHAR_W-1:0] sep, input int count,
                               input bit leave_open);
      int goal;
      set_separator(sep);
      goal = random_items + count;
      while (random_items < goal)
         add_random_record(1'b1);
      if (leave_open)
         add_random_record(1'b0);
   endtask

   // main sequence
   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      hold_kick    = 1'b0;
      req_if.valid        = 1'b0;
      req_if.char_code    = '0;
      req_if.carries_char = 1'b0;
      req_if.ends_record  = 1'b0;
      rsp_if.ready        = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed records under the comma separator
      set_separator(SEP_RESET);
      // open quote, literal separator, doubled quote, close before separator
      push_str("\"a,\"\"b\",");
      push_item("c", 1'b1, 1'b1);
      // blanks trimmed around a kept inner quote, end-only request
      push_item(8'd9, 1'b1, 1'b0);
      push_str("x\"y");
      push_item(8'hA0, 1'b1, 1'b0);
      push_item(8'h00, 1'b0, 1'b1);
      // empty record, then an idle request
      push_item(8'hFF, 1'b0, 1'b1);
      push_item(8'h5A, 1'b0, 1'b0);
      // empty leading field, quote closing at record end
      push_str(",\"q");
      push_item(QUOTE_CODE, 1'b1, 1'b1);
      // unbalanced quotes with extreme codes
      push_item(QUOTE_CODE, 1'b1, 1'b0);
      push_item(8'h00, 1'b1, 1'b0);
      push_item(8'hFF, 1'b1, 1'b1);
      drain();

      // random phases; the semicolon phase ends inside an open record
      random_phase(8'd59, 60, 1'b1);
      drain();
      random_phase(QUOTE_CODE, 40, 1'b0);
      drain();
      @(posedge clock);
      hold_kick <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b0;
      random_phase(8'd0, 45, 1'b0);
      drain();
      random_phase(8'd255, 45, 1'b0);
      drain();
      idle_on = 1'b0;
      random_phase(SEP_RESET, 50, 1'b0);
      drain();
      repeat (40) @(posedge clock);

      if (expected_beats.size() > 0) begin
         mismatches++;
         $display("%0d expected responses never arrived", expected_beats.size());
      end
      $display("covered %0d requests in %0d records under separators 44 59 34 0 255",
               req_count, records_done);
      $display("checked %0d responses: %0d truncated, %0d unbalanced records, %0d errors",
               beats_checked, trunc_beats, unbalanced_records, mismatches);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // run limit
   initial begin
      #(TIMEOUT_TIME);
      $display("timeout with %0d responses outstanding", expected_beats.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
